// ===== rtl/gpa_pkg.sv =====
package gpa_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R2,
        ST_CHECK,
        ST_GM,
        ST_SQRT,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_ACCUM,
        ST_FINISH
    } gpa_state_t;

    // Shift applied to a partial product before it joins the accumulator
    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64,
        SH_96
    } gpa_shift_t;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic       issue;
        logic       clear;
        gpa_shift_t shift;
    } gpa_mac_ctl_t;

    localparam int ACC_W     = 48;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAV = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT = 8'd1;

    localparam logic [31:0] GRAV_RESET = 32'd19865942;
    localparam logic [31:0] SOFT_RESET = 32'd0;

    // Largest term magnitude, 2^48
    localparam logic [48:0] TERM_CAP = 49'h1_0000_0000_0000;

    localparam logic signed [49:0] ACC_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] ACC_MIN = -50'sd140737488355328;

endpackage

// ===== rtl/gpa_mac.sv =====
module gpa_mac
    import gpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  gpa_mac_ctl_t ctl,
    input  logic [31:0]  op_a,
    input  logic [31:0]  op_b,
    output logic [99:0]  acc
);

    logic [63:0] prod_reg;
    gpa_shift_t  sh_reg;
    logic        vld_reg;
    logic [99:0] acc_reg;
    logic [99:0] acc_next;
    logic [99:0] shifted;

    // Product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        sh_reg   <= ctl.shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            vld_reg <= ctl.issue;
            acc_reg <= acc_next;
        end
    end

    // Align the partial product
    always_comb
    begin
        case (sh_reg)
            SH_0:    shifted = {36'd0, prod_reg};
            SH_32:   shifted = {4'd0, prod_reg, 32'd0};
            SH_64:   shifted = {prod_reg[35:0], 64'd0};
            SH_96:   shifted = {prod_reg[3:0], 96'd0};
            default: shifted = '0;
        endcase
    end

    // Accumulate stage
    always_comb
    begin
        if (ctl.clear)
            acc_next = '0;
        else if (vld_reg)
            acc_next = acc_reg + shifted;
        else
            acc_next = acc_reg;
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/gpa_sqrt.sv =====
module gpa_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [65:0] radicand,
    output logic        done,
    output logic [33:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [67:0] rad_reg;
    logic [35:0] rem_reg;
    logic [33:0] root_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    // One root bit a cycle, restoring
    assign rem_sh = {rem_reg[33:0], rad_reg[67:66]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd34;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {2'b00, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[65:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[32:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[32:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/gpa_div.sv =====
module gpa_div
    import gpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [103:0] num,
    input  logic [99:0]  den,
    output logic         done,
    output logic [48:0]  quot
);

    logic         busy_reg;
    logic         done_reg;
    logic [5:0]   cnt_reg;
    logic [100:0] rem_reg;
    logic [49:0]  low_reg;
    logic [49:0]  q_reg;
    logic         ovf_reg;
    logic [99:0]  den_reg;
    logic [100:0] rem_sh;
    logic [100:0] den_ext;

    // One quotient bit a cycle, restoring
    assign rem_sh  = {rem_reg[99:0], low_reg[49]};
    assign den_ext = {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd50;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // quotient of 2^50 or more is capped anyway
            rem_reg <= {47'd0, num[103:50]};
            low_reg <= num[49:0];
            ovf_reg <= ({46'd0, num[103:50]} >= den);
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            low_reg <= {low_reg[48:0], 1'b0};
            if (rem_sh >= den_ext)
            begin
                rem_reg <= rem_sh - den_ext;
                q_reg   <= {q_reg[48:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[48:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = (ovf_reg || (q_reg > {1'b0, TERM_CAP})) ? TERM_CAP : q_reg[48:0];

endmodule

// ===== rtl/gravity_pair_accel_accumulate.sv =====
// Softened pairwise gravity accumulator.
// Input stream (s_*): one beat per target/source pair; s_tlast marks the last
// source for the current target. Output stream (m_*): one beat per target,
// carrying the three summed accelerations and a saturation flag.
// Config channel (cfg_*): index 0 writes the gravitational constant (Q0.32),
// index 1 the softening length (Q16.16); other indexes are dropped.
// Each pair runs through one shared 32x32 multiply-accumulate unit, a
// bit-serial square root and a bit-serial divider (run once per axis, three
// axes). A pair inside the source's exclusion radius skips the root and the
// divides; for any other pair the time from beat to beat is set mostly by the divider.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; the next pair is accepted while it
// waits, and only a further last beat waits for m_tready.
// Reset clears the sums, the clip flag and the output valid, and loads the
// config registers with their defaults.
module gravity_pair_accel_accumulate
    import gpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // target_x, target_y, target_z, source_x, source_y, source_z,
    // source_mass, source_radius_sq (from bit 0)
    input  logic [271:0]         s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accel_x, accel_y, accel_z (from bit 0)
    output logic [143:0]         m_tdata,
    // saturated
    output logic                 m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    gpa_state_t state_reg, state_next;

    logic [31:0]  grav_reg;
    logic [31:0]  soft_reg;
    logic [31:0]  mag_reg [3];
    logic [2:0]   neg_reg;
    logic [31:0]  mass_reg;
    logic [47:0]  rad_reg;
    logic         last_reg;
    logic [65:0]  r2_reg;
    logic [63:0]  gm_reg;
    logic [33:0]  r_reg;
    logic [99:0]  den_reg;
    logic [1:0]   axis_reg;
    logic [2:0]   cnt_reg;
    logic signed [ACC_W-1:0] sums_reg [3];
    logic         clip_reg;
    logic         m_valid_reg;
    logic [143:0] m_data_reg;
    logic         m_user_reg;

    gpa_mac_ctl_t mac_ctl;
    logic [31:0]  op_a, op_b;
    logic [99:0]  mac_acc;
    logic         sqrt_start, sqrt_done;
    logic [33:0]  sqrt_root;
    logic         div_start, div_done;
    logic [48:0]  div_quot;

    logic         in_fire;
    logic         out_load;
    logic [32:0]  d_in [3];
    logic [31:0]  mag_sel;
    logic signed [49:0] term;
    logic signed [49:0] sum_raw;
    logic signed [47:0] sum_sat;
    logic         sum_clip;

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign mag_sel   = mag_reg[axis_reg];

    // Separation per axis, source minus target
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_in[k] = {s_tdata[96 + 32*k + 31], s_tdata[96 + 32*k +: 32]}
                    - {s_tdata[32*k + 31], s_tdata[32*k +: 32]};
        end
    end

    // Shared units
    gpa_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (mac_acc)
    );

    gpa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (r2_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    gpa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({mac_acc[95:0], 8'd0}),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_R2;
            ST_R2:     if (cnt_reg == 3'd5) state_next = ST_CHECK;
            ST_CHECK:  state_next = (r2_reg > {2'b00, rad_reg, 16'd0}) ? ST_GM : ST_FINISH;
            ST_GM:     if (cnt_reg == 3'd2) state_next = ST_SQRT;
            ST_SQRT:   if (sqrt_done) state_next = ST_DEN;
            ST_DEN:    if (cnt_reg == 3'd7) state_next = ST_NUM;
            ST_NUM:    if (cnt_reg == 3'd3) state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_ACCUM;
            ST_ACCUM:  state_next = (axis_reg == 2'd2) ? ST_FINISH : ST_NUM;
            ST_FINISH:
            begin
                if (!last_reg || !m_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, unit starts and s_tready
    always_comb
    begin
        mac_ctl    = '{issue: 1'b0, clear: 1'b0, shift: SH_0};
        op_a       = '0;
        op_b       = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_R2:
            begin
                // |d|^2 per axis plus softening^2
                if (cnt_reg < 3'd4)
                begin
                    mac_ctl.issue = 1'b1;
                    mac_ctl.clear = (cnt_reg == 3'd0);
                    case (cnt_reg[1:0])
                        2'd0:    begin op_a = mag_reg[0]; op_b = mag_reg[0]; end
                        2'd1:    begin op_a = mag_reg[1]; op_b = mag_reg[1]; end
                        2'd2:    begin op_a = mag_reg[2]; op_b = mag_reg[2]; end
                        default: begin op_a = soft_reg;   op_b = soft_reg;   end
                    endcase
                end
            end
            ST_GM:
            begin
                if (cnt_reg == 3'd0)
                begin
                    mac_ctl.issue = 1'b1;
                    mac_ctl.clear = 1'b1;
                    op_a          = grav_reg;
                    op_b          = mass_reg;
                end
                sqrt_start = (cnt_reg == 3'd2);
            end
            ST_DEN:
            begin
                // r2 * r over 32-bit partial products
                if (cnt_reg < 3'd6)
                begin
                    mac_ctl.issue = 1'b1;
                    mac_ctl.clear = (cnt_reg == 3'd0);
                    case (cnt_reg)
                        3'd0:
                        begin
                            op_a = r2_reg[31:0];  op_b = r_reg[31:0];
                            mac_ctl.shift = SH_0;
                        end
                        3'd1:
                        begin
                            op_a = r2_reg[31:0];  op_b = {30'd0, r_reg[33:32]};
                            mac_ctl.shift = SH_32;
                        end
                        3'd2:
                        begin
                            op_a = r2_reg[63:32]; op_b = r_reg[31:0];
                            mac_ctl.shift = SH_32;
                        end
                        3'd3:
                        begin
                            op_a = r2_reg[63:32]; op_b = {30'd0, r_reg[33:32]};
                            mac_ctl.shift = SH_64;
                        end
                        3'd4:
                        begin
                            op_a = {30'd0, r2_reg[65:64]}; op_b = r_reg[31:0];
                            mac_ctl.shift = SH_64;
                        end
                        default:
                        begin
                            op_a = {30'd0, r2_reg[65:64]}; op_b = {30'd0, r_reg[33:32]};
                            mac_ctl.shift = SH_96;
                        end
                    endcase
                end
            end
            ST_NUM:
            begin
                // G * mass * |d| for the current axis
                if (cnt_reg < 3'd2)
                begin
                    mac_ctl.issue = 1'b1;
                    mac_ctl.clear = (cnt_reg == 3'd0);
                    op_b          = mag_sel;
                    if (cnt_reg == 3'd0)
                    begin
                        op_a          = gm_reg[31:0];
                        mac_ctl.shift = SH_0;
                    end
                    else
                    begin
                        op_a          = gm_reg[63:32];
                        mac_ctl.shift = SH_32;
                    end
                end
                div_start = (cnt_reg == 3'd3);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Signed term and saturating add
    always_comb
    begin
        term     = neg_reg[axis_reg] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        sum_raw  = {{2{sums_reg[axis_reg][ACC_W-1]}}, sums_reg[axis_reg]} + term;
        sum_clip = 1'b0;
        if (sum_raw > ACC_MAX)
        begin
            sum_sat  = ACC_MAX[47:0];
            sum_clip = 1'b1;
        end
        else if (sum_raw < ACC_MIN)
        begin
            sum_sat  = ACC_MIN[47:0];
            sum_clip = 1'b1;
        end
        else
        begin
            sum_sat = sum_raw[47:0];
        end
    end

    assign out_load = (state_reg == ST_FINISH) && last_reg && (!m_valid_reg || m_tready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            axis_reg    <= '0;
            grav_reg    <= GRAV_RESET;
            soft_reg    <= SOFT_RESET;
            sums_reg[0] <= '0;
            sums_reg[1] <= '0;
            sums_reg[2] <= '0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 3'd0 : cnt_reg + 3'd1;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_GRAV)
                    grav_reg <= cfg_data;
                else if (cfg_index == CFG_SOFT)
                    soft_reg <= cfg_data;
            end

            if (in_fire)
                axis_reg <= 2'd0;
            else if (state_reg == ST_ACCUM)
                axis_reg <= axis_reg + 2'd1;

            if (state_reg == ST_ACCUM)
            begin
                sums_reg[axis_reg] <= sum_sat;
                if (sum_clip)
                    clip_reg <= 1'b1;
            end
            else if (out_load)
            begin
                sums_reg[0] <= '0;
                sums_reg[1] <= '0;
                sums_reg[2] <= '0;
                clip_reg    <= 1'b0;
            end

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Item and intermediate payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= d_in[k][32];
                mag_reg[k] <= d_in[k][32] ? 32'(-d_in[k]) : d_in[k][31:0];
            end
            mass_reg <= s_tdata[223:192];
            rad_reg  <= s_tdata[271:224];
            last_reg <= s_tlast;
        end
        if (state_reg == ST_R2 && cnt_reg == 3'd5)
            r2_reg <= mac_acc[65:0];
        if (state_reg == ST_GM && cnt_reg == 3'd2)
            gm_reg <= mac_acc[63:0];
        if (state_reg == ST_SQRT && sqrt_done)
            r_reg <= sqrt_root;
        if (state_reg == ST_DEN && cnt_reg == 3'd7)
            den_reg <= mac_acc;
        if (out_load)
        begin
            m_data_reg <= {sums_reg[2], sums_reg[1], sums_reg[0]};
            m_user_reg <= clip_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
